[rtl/bmh_pkg.sv]
// Shared types and constants of the binned-mean two-dimensional histogram.
`timescale 1ns / 1ps
`default_nettype none
package bmh_pkg;

  // Default histogram dimensions.
  localparam int MAX_DISTANCE_BINS_DEF = 128;
  localparam int MAX_ANGLE_BINS_DEF    = 128;

  // Field and store widths.
  localparam int COORD_W   = 16;
  localparam int ENERGY_W  = 32;
  localparam int VALUE_W   = 31;
  localparam int LIMIT_W   = 47;
  localparam int SUM_W     = 48;
  localparam int COUNT_W   = 16;
  localparam int USED_W    = 8;
  localparam int BIN_OUT_W = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 47;
  localparam int WORD_W    = COUNT_W + SUM_W;

  // Input item kinds.
  localparam logic KIND_HIT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_USED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_USED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SUM_LIMIT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_FALLBK  = 3'd6;

  // Configuration reset values.
  localparam logic [COORD_W-1:0] RST_DIST_WIDTH   = 16'd145;
  localparam logic [COORD_W-1:0] RST_ANGLE_WIDTH  = 16'd271;
  localparam logic [USED_W-1:0]  RST_DIST_USED    = 8'd85;
  localparam logic [USED_W-1:0]  RST_ANGLE_USED   = 8'd85;
  localparam logic [VALUE_W-1:0] RST_ENERGY_LIMIT = 31'd1048576;
  localparam logic [LIMIT_W-1:0] RST_SUM_LIMIT    = 47'd6553600;
  localparam logic [VALUE_W-1:0] RST_INIT_FALLBK  = 31'd58982;

  // A bin count at this value is saturated.
  localparam logic [COUNT_W-1:0] COUNT_SAT = 16'hFFFF;

  // Shared divider: dividend width, step counter and step counts per use.
  localparam int DIVD_W  = SUM_W;
  localparam int STEP_W  = 6;
  localparam logic [STEP_W-1:0] BIN_DIV_STEPS  = 6'd16;
  localparam logic [STEP_W-1:0] MEAN_DIV_STEPS = 6'd48;

  // Request to the shared divider.
  typedef struct packed {
    logic                start;
    logic [STEP_W-1:0]   steps;
    logic [DIVD_W-1:0]   dividend;
    logic [COUNT_W-1:0]  divisor;
  } div_req_t;

  // Response from the shared divider.
  typedef struct packed {
    logic                done;
    logic [DIVD_W-1:0]   quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

[rtl/binned_mean_2d_histogram.sv]
// Top level of the binned-mean two-dimensional histogram.
`timescale 1ns / 1ps
`default_nettype none
// Each hit is binned by dividing its distance and angle by the bin widths,
// then accepted into a count/sum bin store; each readout item returns the
// mean of the next bin in row-major order, or the fallback value (the last
// computed mean or configured value, whichever is newer) when the bin is
// empty or its sum is over the limit. All divisions run on one shared
// one-bit-per-cycle divider, and one item is in work at a time: a hit takes
// two 16-step divisions plus a read-modify-write of the bin store, a readout
// one 48-step division of sum by count, and a fallback readout none. The
// finished result sits in an output register, so the next item can start
// while it waits to be taken. After reset the bin store is cleared one entry
// per cycle, MAX_DISTANCE_BINS * MAX_ANGLE_BINS entries (16384 by default),
// and no item is taken meanwhile; configuration writes are taken at any time.
module binned_mean_2d_histogram #(
  parameter int MAX_DISTANCE_BINS = bmh_pkg::MAX_DISTANCE_BINS_DEF,
  parameter int MAX_ANGLE_BINS    = bmh_pkg::MAX_ANGLE_BINS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_kind,
  input  wire logic [bmh_pkg::COORD_W-1:0]       in_distance,
  input  wire logic [bmh_pkg::COORD_W-1:0]       in_angle,
  input  wire logic signed [bmh_pkg::ENERGY_W-1:0] in_energy,
  // Result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_accepted,
  output logic [bmh_pkg::BIN_OUT_W-1:0]          out_bin_row,
  output logic [bmh_pkg::BIN_OUT_W-1:0]          out_bin_col,
  output logic [bmh_pkg::VALUE_W-1:0]            out_mean_value,
  output logic                                   out_used_fallback,
  output logic                                   out_last_of_scan,
  // Configuration port
  input  wire logic                              cfg_wr_en,
  input  wire logic [bmh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bmh_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int NBINS  = MAX_DISTANCE_BINS * MAX_ANGLE_BINS;
  localparam int ADDR_W = (NBINS > 1) ? $clog2(NBINS) : 1;
  localparam int ROW_W  = (MAX_DISTANCE_BINS > 1) ? $clog2(MAX_DISTANCE_BINS) : 1;
  localparam int COL_W  = (MAX_ANGLE_BINS > 1) ? $clog2(MAX_ANGLE_BINS) : 1;
  localparam int RC_W   = $clog2(MAX_DISTANCE_BINS + 1);
  localparam int CC_W   = $clog2(MAX_ANGLE_BINS + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NBINS - 1);

  // Sequencer states.
  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DIV_ROW  = 4'd2;
  localparam logic [3:0] S_DIV_COL  = 4'd3;
  localparam logic [3:0] S_HIT_CHK  = 4'd4;
  localparam logic [3:0] S_MEM_WAIT = 4'd5;
  localparam logic [3:0] S_HIT_UPD  = 4'd6;
  localparam logic [3:0] S_RD_WAIT  = 4'd7;
  localparam logic [3:0] S_RD_EVAL  = 4'd8;
  localparam logic [3:0] S_DIV_MEAN = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  // Configuration registers.
  logic [bmh_pkg::COORD_W-1:0] dist_width_r;
  logic [bmh_pkg::COORD_W-1:0] angle_width_r;
  logic [bmh_pkg::USED_W-1:0]  dist_used_r;
  logic [bmh_pkg::USED_W-1:0]  angle_used_r;
  logic [bmh_pkg::VALUE_W-1:0] energy_limit_r;
  logic [bmh_pkg::LIMIT_W-1:0] sum_limit_r;
  logic [bmh_pkg::VALUE_W-1:0] fallback_value_r;

  // Sequencer and scan state.
  logic [3:0]        state_r;
  logic [3:0]        state_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ROW_W-1:0]  scan_row_r;
  logic [COL_W-1:0]  scan_col_r;

  // Item working registers.
  logic [bmh_pkg::COORD_W-1:0]  angle_r;
  logic [bmh_pkg::ENERGY_W-1:0] energy_r;
  logic [bmh_pkg::COORD_W-1:0]  row_q_r;
  logic [bmh_pkg::COORD_W-1:0]  col_q_r;
  logic [ROW_W-1:0]             rd_row_r;
  logic [COL_W-1:0]             rd_col_r;

  // Pending result.
  logic                          res_accepted_r;
  logic [bmh_pkg::BIN_OUT_W-1:0] res_row_r;
  logic [bmh_pkg::BIN_OUT_W-1:0] res_col_r;
  logic [bmh_pkg::VALUE_W-1:0]   res_mean_r;
  logic                          res_fb_r;
  logic                          res_last_r;

  // Output register.
  logic                          out_valid_r;
  logic                          out_accepted_r;
  logic [bmh_pkg::BIN_OUT_W-1:0] out_row_r;
  logic [bmh_pkg::BIN_OUT_W-1:0] out_col_r;
  logic [bmh_pkg::VALUE_W-1:0]   out_mean_r;
  logic                          out_fb_r;
  logic                          out_last_r;

  // Bin store: count in the upper bits, sum in the lower bits.
  logic [bmh_pkg::WORD_W-1:0] bin_mem [NBINS];
  logic [bmh_pkg::WORD_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]          mem_addr_r;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [bmh_pkg::WORD_W-1:0] mem_wdata;

  logic [bmh_pkg::COUNT_W-1:0] rd_cnt;
  logic [bmh_pkg::SUM_W-1:0]   rd_sum;

  // Divider interface.
  bmh_pkg::div_req_t div_req;
  bmh_pkg::div_rsp_t div_rsp;

  // Derived control values.
  logic [RC_W-1:0]   eff_rows;
  logic [CC_W-1:0]   eff_cols;
  logic              in_xfer;
  logic              out_free;
  logic              hit_ok;
  logic [ADDR_W-1:0] hit_addr;
  logic              scan_out_of_range;
  logic [ROW_W-1:0]  sel_row;
  logic [COL_W-1:0]  sel_col;
  logic [ADDR_W-1:0] sel_addr;
  logic              use_fallback;
  logic [CC_W-1:0]   col_p1;
  logic [RC_W-1:0]   row_p1;
  logic [ROW_W-1:0]  next_row;
  logic [COL_W-1:0]  next_col;
  logic              scan_last;

  bmh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign rd_cnt = rd_data_r[bmh_pkg::WORD_W-1:bmh_pkg::SUM_W];
  assign rd_sum = rd_data_r[bmh_pkg::SUM_W-1:0];

  // Bins in use, with zero acting as one and large values clipped to the maximum.
  always_comb begin
    if (dist_used_r == '0) begin
      eff_rows = RC_W'(1);
    end else if (int'(dist_used_r) > MAX_DISTANCE_BINS) begin
      eff_rows = RC_W'(MAX_DISTANCE_BINS);
    end else begin
      eff_rows = RC_W'(dist_used_r);
    end
    if (angle_used_r == '0) begin
      eff_cols = CC_W'(1);
    end else if (int'(angle_used_r) > MAX_ANGLE_BINS) begin
      eff_cols = CC_W'(MAX_ANGLE_BINS);
    end else begin
      eff_cols = CC_W'(angle_used_r);
    end
  end

  // Hit acceptance and its bin address.
  always_comb begin
    hit_ok = (row_q_r < bmh_pkg::COORD_W'(eff_rows)) &&
             (col_q_r < bmh_pkg::COORD_W'(eff_cols)) &&
             !energy_r[bmh_pkg::ENERGY_W-1] &&
             (energy_r[bmh_pkg::VALUE_W-1:0] <= energy_limit_r);
    hit_addr = ADDR_W'(row_q_r[ROW_W-1:0] * MAX_ANGLE_BINS + col_q_r[COL_W-1:0]);
  end

  // Readout bin selection: a scan position outside the bins in use restarts.
  always_comb begin
    scan_out_of_range = (RC_W'(scan_row_r) >= eff_rows) ||
                        (CC_W'(scan_col_r) >= eff_cols);
    sel_row  = scan_out_of_range ? '0 : scan_row_r;
    sel_col  = scan_out_of_range ? '0 : scan_col_r;
    sel_addr = ADDR_W'(sel_row * MAX_ANGLE_BINS + sel_col);
  end

  // Scan advance and the fallback decision for the bin just read.
  always_comb begin
    col_p1    = CC_W'(rd_col_r) + CC_W'(1);
    row_p1    = RC_W'(rd_row_r) + RC_W'(1);
    scan_last = 1'b0;
    if (col_p1 >= eff_cols) begin
      next_col = '0;
      if (row_p1 >= eff_rows) begin
        next_row  = '0;
        scan_last = 1'b1;
      end else begin
        next_row = ROW_W'(row_p1);
      end
    end else begin
      next_col = COL_W'(col_p1);
      next_row = rd_row_r;
    end
    use_fallback = (rd_cnt == '0) || (rd_sum > {1'b0, sum_limit_r});
  end

  // Sequencer next state, divider requests and bin store writes.
  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.steps    = bmh_pkg::BIN_DIV_STEPS;
    div_req.dividend = {in_distance, (bmh_pkg::DIVD_W - bmh_pkg::COORD_W)'(0)};
    div_req.divisor  = dist_width_r;
    mem_we           = 1'b0;
    mem_waddr        = mem_addr_r;
    mem_wdata        = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          if (in_kind == bmh_pkg::KIND_HIT) begin
            div_req.start = 1'b1;
            state_nxt     = S_DIV_ROW;
          end else begin
            state_nxt = S_RD_WAIT;
          end
        end
      end
      S_DIV_ROW: begin
        div_req.dividend = {angle_r, (bmh_pkg::DIVD_W - bmh_pkg::COORD_W)'(0)};
        div_req.divisor  = angle_width_r;
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV_COL;
        end
      end
      S_DIV_COL: begin
        if (div_rsp.done) begin
          state_nxt = S_HIT_CHK;
        end
      end
      S_HIT_CHK: begin
        state_nxt = hit_ok ? S_MEM_WAIT : S_DONE;
      end
      S_MEM_WAIT: begin
        state_nxt = S_HIT_UPD;
      end
      S_HIT_UPD: begin
        if (rd_cnt != bmh_pkg::COUNT_SAT) begin
          mem_we    = 1'b1;
          mem_wdata = {rd_cnt + bmh_pkg::COUNT_W'(1),
                       rd_sum + bmh_pkg::SUM_W'(energy_r[bmh_pkg::VALUE_W-1:0])};
        end
        state_nxt = S_DONE;
      end
      S_RD_WAIT: begin
        state_nxt = S_RD_EVAL;
      end
      S_RD_EVAL: begin
        div_req.steps    = bmh_pkg::MEAN_DIV_STEPS;
        div_req.dividend = rd_sum;
        div_req.divisor  = rd_cnt;
        if (use_fallback) begin
          state_nxt = S_DONE;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV_MEAN;
        end
      end
      S_DIV_MEAN: begin
        if (div_rsp.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Bin store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= bin_mem[mem_addr_r];
  end

  // Control state: sequencer, clearing pass, scan position, configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_CLEAR;
      clr_addr_r       <= '0;
      scan_row_r       <= '0;
      scan_col_r       <= '0;
      out_valid_r      <= 1'b0;
      dist_width_r     <= bmh_pkg::RST_DIST_WIDTH;
      angle_width_r    <= bmh_pkg::RST_ANGLE_WIDTH;
      dist_used_r      <= bmh_pkg::RST_DIST_USED;
      angle_used_r     <= bmh_pkg::RST_ANGLE_USED;
      energy_limit_r   <= bmh_pkg::RST_ENERGY_LIMIT;
      sum_limit_r      <= bmh_pkg::RST_SUM_LIMIT;
      fallback_value_r <= bmh_pkg::RST_INIT_FALLBK;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (state_r == S_RD_EVAL) begin
        scan_row_r <= next_row;
        scan_col_r <= next_col;
      end
      // A new mean becomes the fallback for later empty or over-limit bins.
      if (state_r == S_DIV_MEAN && div_rsp.done) begin
        fallback_value_r <= div_rsp.quotient[bmh_pkg::VALUE_W-1:0];
      end
      // Output register: cleared on transfer, loaded when a result is done.
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      // Configuration writes.
      if (cfg_wr_en) begin
        unique case (cfg_index)
          bmh_pkg::CFG_DIST_WIDTH:   dist_width_r   <= cfg_data[bmh_pkg::COORD_W-1:0];
          bmh_pkg::CFG_ANGLE_WIDTH:  angle_width_r  <= cfg_data[bmh_pkg::COORD_W-1:0];
          bmh_pkg::CFG_DIST_USED:    dist_used_r    <= cfg_data[bmh_pkg::USED_W-1:0];
          bmh_pkg::CFG_ANGLE_USED:   angle_used_r   <= cfg_data[bmh_pkg::USED_W-1:0];
          bmh_pkg::CFG_ENERGY_LIMIT: energy_limit_r <= cfg_data[bmh_pkg::VALUE_W-1:0];
          bmh_pkg::CFG_SUM_LIMIT:    sum_limit_r    <= cfg_data[bmh_pkg::LIMIT_W-1:0];
          bmh_pkg::CFG_INIT_FALLBK:  fallback_value_r <= cfg_data[bmh_pkg::VALUE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Item payload and result registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          angle_r    <= in_angle;
          energy_r   <= in_energy;
          rd_row_r   <= sel_row;
          rd_col_r   <= sel_col;
          mem_addr_r <= sel_addr;
        end
      end
      S_DIV_ROW: begin
        if (div_rsp.done) begin
          row_q_r <= div_rsp.quotient[bmh_pkg::COORD_W-1:0];
        end
      end
      S_DIV_COL: begin
        if (div_rsp.done) begin
          col_q_r <= div_rsp.quotient[bmh_pkg::COORD_W-1:0];
        end
      end
      S_HIT_CHK: begin
        mem_addr_r     <= hit_addr;
        res_accepted_r <= 1'b0;
        res_row_r      <= bmh_pkg::BIN_OUT_W'(row_q_r);
        res_col_r      <= bmh_pkg::BIN_OUT_W'(col_q_r);
        res_mean_r     <= '0;
        res_fb_r       <= 1'b0;
        res_last_r     <= 1'b0;
      end
      S_HIT_UPD: begin
        res_accepted_r <= (rd_cnt != bmh_pkg::COUNT_SAT);
      end
      S_RD_EVAL: begin
        res_accepted_r <= 1'b0;
        res_row_r      <= bmh_pkg::BIN_OUT_W'(rd_row_r);
        res_col_r      <= bmh_pkg::BIN_OUT_W'(rd_col_r);
        res_last_r     <= scan_last;
        res_fb_r       <= use_fallback;
        res_mean_r     <= fallback_value_r;
      end
      S_DIV_MEAN: begin
        if (div_rsp.done) begin
          res_mean_r <= div_rsp.quotient[bmh_pkg::VALUE_W-1:0];
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_accepted_r <= res_accepted_r;
          out_row_r      <= res_row_r;
          out_col_r      <= res_col_r;
          out_mean_r     <= res_mean_r;
          out_fb_r       <= res_fb_r;
          out_last_r     <= res_last_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_accepted_r;
  assign out_bin_row       = out_row_r;
  assign out_bin_col       = out_col_r;
  assign out_mean_value    = out_mean_r;
  assign out_used_fallback = out_fb_r;
  assign out_last_of_scan  = out_last_r;

endmodule
`default_nettype wire

[rtl/bmh_div.sv]
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bmh_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bmh_pkg::div_req_t req,
  output bmh_pkg::div_rsp_t     rsp
);

  logic                            busy_r;
  logic                            done_r;
  logic [bmh_pkg::STEP_W-1:0]      cnt_r;
  logic [bmh_pkg::DIVD_W-1:0]      dq_r;
  logic [bmh_pkg::COUNT_W-1:0]     rem_r;
  logic [bmh_pkg::COUNT_W-1:0]     den_r;

  logic [bmh_pkg::COUNT_W:0]       shifted;
  logic [bmh_pkg::COUNT_W:0]       diff;
  logic                            ge;

  // One restoring step: shift in the next dividend bit and try the subtract.
  // A zero divisor always subtracts, which yields an all-ones quotient.
  always_comb begin
    shifted = {rem_r, dq_r[bmh_pkg::DIVD_W-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = (shifted >= {1'b0, den_r});
  end

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - bmh_pkg::STEP_W'(1);
        if (cnt_r == bmh_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend is consumed from the top while quotient bits
  // enter at the bottom of the same register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dq_r  <= req.dividend;
      rem_r <= '0;
      den_r <= req.divisor;
    end else if (busy_r) begin
      dq_r  <= {dq_r[bmh_pkg::DIVD_W-2:0], ge};
      rem_r <= ge ? diff[bmh_pkg::COUNT_W-1:0] : shifted[bmh_pkg::COUNT_W-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dq_r;

endmodule
`default_nettype wire
